FILE: src/sca_pkg.sv
// Shared types, constants and the microcode table of the stack calculator.
package sca_pkg;

  // Widths fixed by the item format.
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OPC_W           = 3;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned DEPTH_W         = 5;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Operation codes of an input item.
  localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPC_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OPC_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OPC_W-1:0] OP_SUB  = 3'd4;

  // Status codes of a result item.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_FEW  = 2'd2,
    STAT_DIVZ = 2'd3
  } status_e;

  // Microcode addresses.
  typedef enum logic [3:0] {
    U_FETCH     = 4'd0,
    U_CHK_PUSH  = 4'd1,
    U_CHK_FULL  = 4'd2,
    U_PUSH      = 4'd3,
    U_CHK_OP    = 4'd4,
    U_RD_LEFT   = 4'd5,
    U_LD_LEFT   = 4'd6,
    U_DIV_CHK   = 4'd7,
    U_DIV_WAIT  = 4'd8,
    U_EXEC      = 4'd9,
    U_WRITE     = 4'd10,
    U_OUT_WAIT  = 4'd11,
    U_EMIT      = 4'd12,
    U_ERR_FULL  = 4'd13,
    U_ERR_FEW   = 4'd14,
    U_ERR_DIVZ  = 4'd15
  } step_e;

  // Jump conditions; a taken jump loads the target, otherwise the step counter advances.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_IN     = 4'd2,
    C_NOT_PUSH  = 4'd3,
    C_FULL      = 4'd4,
    C_BAD_OP    = 4'd5,
    C_FEW       = 4'd6,
    C_NOT_DIV   = 4'd7,
    C_BZERO     = 4'd8,
    C_DIV_BUSY  = 4'd9,
    C_OUT_BLOCK = 4'd10
  } cond_e;

  // Datapath controls carried by one microcode word.
  typedef struct packed {
    logic    in_rdy;
    logic    push_wr;
    logic    rd_second;
    logic    ld_a;
    logic    div_start;
    logic    ld_r;
    logic    res_wr;
    logic    set_status;
    status_e status;
    logic    emit;
  } dp_ctrl_t;

  typedef struct packed {
    cond_e    cond;
    step_e    target;
    dp_ctrl_t ctrl;
  } uword_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic not_push;
    logic full;
    logic bad_op;
    logic few;
    logic not_div;
    logic bzero;
    logic div_busy;
    logic out_block;
  } flags_t;

  // Microcode ROM.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '0;
    unique case (s)
      U_FETCH: begin
        w.ctrl.in_rdy = 1'b1;
        w.cond        = C_NO_IN;
        w.target      = U_FETCH;
      end
      U_CHK_PUSH: begin
        w.cond   = C_NOT_PUSH;
        w.target = U_CHK_OP;
      end
      U_CHK_FULL: begin
        w.cond   = C_FULL;
        w.target = U_ERR_FULL;
      end
      U_PUSH: begin
        w.ctrl.push_wr = 1'b1;
        w.cond         = C_ALWAYS;
        w.target       = U_OUT_WAIT;
      end
      U_CHK_OP: begin
        w.cond   = C_BAD_OP;
        w.target = U_OUT_WAIT;
      end
      U_RD_LEFT: begin
        w.ctrl.rd_second = 1'b1;
        w.cond           = C_FEW;
        w.target         = U_ERR_FEW;
      end
      U_LD_LEFT: begin
        w.ctrl.ld_a = 1'b1;
        w.cond      = C_NOT_DIV;
        w.target    = U_EXEC;
      end
      U_DIV_CHK: begin
        w.ctrl.div_start = 1'b1;
        w.cond           = C_BZERO;
        w.target         = U_ERR_DIVZ;
      end
      U_DIV_WAIT: begin
        w.cond   = C_DIV_BUSY;
        w.target = U_DIV_WAIT;
      end
      U_EXEC: begin
        w.ctrl.ld_r = 1'b1;
      end
      U_WRITE: begin
        w.ctrl.res_wr = 1'b1;
      end
      U_OUT_WAIT: begin
        w.cond   = C_OUT_BLOCK;
        w.target = U_OUT_WAIT;
      end
      U_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = U_FETCH;
      end
      U_ERR_FULL: begin
        w.ctrl.set_status = 1'b1;
        w.ctrl.status     = STAT_FULL;
        w.cond            = C_ALWAYS;
        w.target          = U_OUT_WAIT;
      end
      U_ERR_FEW: begin
        w.ctrl.set_status = 1'b1;
        w.ctrl.status     = STAT_FEW;
        w.cond            = C_ALWAYS;
        w.target          = U_OUT_WAIT;
      end
      U_ERR_DIVZ: begin
        w.ctrl.set_status = 1'b1;
        w.ctrl.status     = STAT_DIVZ;
        w.cond            = C_ALWAYS;
        w.target          = U_OUT_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/sca_in_if.sv
// Input channel: one push or operation item per transfer.
interface sca_in_if;
  logic                          valid;
  logic                          ready;
  logic [sca_pkg::OPC_W-1:0]     opcode;
  logic signed [sca_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

FILE: src/sca_out_if.sv
// Output channel: one result item per transfer.
interface sca_out_if;
  logic                              valid;
  logic                              ready;
  logic [sca_pkg::STAT_W-1:0]        status;
  logic [sca_pkg::DEPTH_W-1:0]       depth;
  logic signed [sca_pkg::DATA_W-1:0] top_value;

  modport source (output valid, output status, output depth, output top_value, input ready);
  modport sink   (input valid, input status, input depth, input top_value, output ready);
endinterface

FILE: src/sca_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module sca_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sca_pkg::DATA_W-1:0]  dividend_i,
  input  logic [sca_pkg::DATA_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [sca_pkg::DATA_W-1:0]  quot_o
);
  import sca_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic              neg_q;
  logic [DATA_W:0]   rem_sh, diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // Control: count the quotient bits still to produce.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DATA_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands are held as magnitudes; the sign is applied at the output.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

FILE: src/sca_dpath.sv
// Datapath: operand stack memory, operand and result registers, ALU and output register.
module sca_dpath #(
  parameter int unsigned STACK_DEPTH = sca_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sca_pkg::dp_ctrl_t                 ctrl_i,
  output sca_pkg::flags_t                   flags_o,
  input  logic                              in_valid_i,
  input  logic [sca_pkg::OPC_W-1:0]         opcode_i,
  input  logic [sca_pkg::DATA_W-1:0]        push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sca_pkg::STAT_W-1:0]        status_o,
  output logic [sca_pkg::DEPTH_W-1:0]       depth_o,
  output logic [sca_pkg::DATA_W-1:0]        top_value_o
);
  import sca_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic              accept;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     count_m2;
  logic [OPC_W-1:0]  op_q;
  logic [DATA_W-1:0] val_q, top_q, a_q, r_q, rdata_q, alu_res, quot;
  status_e           status_q;
  logic              div_busy;
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [DATA_W-1:0] out_top_q;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign accept   = in_valid_i & ctrl_i.in_rdy;
  assign count_m2 = count_q - CW'(2);

  // Conditions for the sequencer's jumps.
  always_comb begin
    flags_o.in_valid  = in_valid_i;
    flags_o.not_push  = (op_q != OP_PUSH);
    flags_o.full      = (count_q >= CW'(STACK_DEPTH));
    flags_o.bad_op    = (op_q > OP_SUB);
    flags_o.few       = (count_q < CW'(2));
    flags_o.not_div   = (op_q != OP_DIV);
    flags_o.bzero     = (top_q == '0);
    flags_o.div_busy  = div_busy;
    flags_o.out_block = out_valid_q & ~out_ready_i;
  end

  // Item latch and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_PUSH;
      status_q <= STAT_OK;
    end else if (accept) begin
      op_q     <= opcode_i;
      status_q <= STAT_OK;
    end else if (ctrl_i.set_status) begin
      status_q <= ctrl_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= push_value_i;
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (ctrl_i.push_wr) begin
      count_d = count_q + CW'(1);
    end else if (ctrl_i.res_wr) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Stack memory: one write port, one registered read port for the left operand.
  assign wr_addr = ctrl_i.push_wr ? count_q[AW-1:0] : count_m2[AW-1:0];
  assign wr_data = ctrl_i.push_wr ? val_q : r_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push_wr || ctrl_i.res_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_second) begin
      rdata_q <= mem[count_m2[AW-1:0]];
    end
  end

  // The top entry is also kept in a register so it is always at hand.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push_wr) begin
      top_q <= val_q;
    end else if (ctrl_i.res_wr) begin
      top_q <= r_q;
    end
    if (ctrl_i.ld_a) begin
      a_q <= rdata_q;
    end
    if (ctrl_i.ld_r) begin
      r_q <= alu_res;
    end
  end

  sca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (a_q),
    .divisor_i  (top_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // ALU: left operand is the second entry, right operand is the top.
  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_res = a_q + top_q;
      OP_MUL:  alu_res = DATA_W'(a_q * top_q);
      OP_DIV:  alu_res = quot;
      default: alu_res = a_q - top_q;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_status_q <= status_q;
      out_depth_q  <= DEPTH_W'(count_q);
      out_top_q    <= (count_q == '0) ? '0 : top_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign depth_o     = out_depth_q;
  assign top_value_o = out_top_q;

  // Checks on the stack bookkeeping.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(STACK_DEPTH))
    else $error("Entry count beyond the stack depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ctrl_i.push_wr && ctrl_i.res_wr))
    else $error("Push and result write in the same cycle.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.res_wr |-> count_q >= CW'(2))
    else $error("Result written with fewer than two entries.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ctrl_i.push_wr |-> count_q < CW'(STACK_DEPTH))
    else $error("Push into a full stack.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.emit |-> !out_valid_q)
    else $error("Result overwrites one not yet transferred.");

endmodule

FILE: src/sca_useq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module sca_useq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sca_pkg::flags_t    flags_i,
  output sca_pkg::dp_ctrl_t  ctrl_o
);
  import sca_pkg::*;

  step_e  upc_q, upc_d;
  uword_t uw;
  logic   take;

  // Fetch the control word and pick the next step.
  always_comb begin
    uw = ucode(upc_q);
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = ~flags_i.in_valid;
      C_NOT_PUSH:  take = flags_i.not_push;
      C_FULL:      take = flags_i.full;
      C_BAD_OP:    take = flags_i.bad_op;
      C_FEW:       take = flags_i.few;
      C_NOT_DIV:   take = flags_i.not_div;
      C_BZERO:     take = flags_i.bzero;
      C_DIV_BUSY:  take = flags_i.div_busy;
      C_OUT_BLOCK: take = flags_i.out_block;
      default:     take = 1'b0;
    endcase
    upc_d  = take ? uw.target : step_e'(upc_q + 4'd1);
    ctrl_o = uw.ctrl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

FILE: src/stack_calculator_alu.sv
// Top level of the operand stack calculator.
// Each input transfer is a push, an add, multiply, divide or subtract on the two top entries, or
// an unused opcode that leaves the stack as it is; each produces exactly one result transfer with
// status, depth and top value. Items are worked one at a time by a 16-step microprogram, and a
// new item is taken while the previous result still waits in the output register. A divide waits
// on the serial divider, which makes one quotient bit a cycle.
// Each operation reads its left operand through the stack memory's registered read port.
module stack_calculator_alu #(
  parameter int unsigned STACK_DEPTH = sca_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sca_in_if.sink    in_i,
  sca_out_if.source out_o
);
  import sca_pkg::*;

  dp_ctrl_t ctrl;
  flags_t   flags;

  sca_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  sca_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .in_valid_i   (in_i.valid),
    .opcode_i     (in_i.opcode),
    .push_value_i (in_i.push_value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_o     (out_o.status),
    .depth_o      (out_o.depth),
    .top_value_o  (out_o.top_value)
  );

  // The sequencer takes an item only in its fetch step.
  assign in_i.ready = ctrl.in_rdy;

endmodule

FILE: tb/stack_calculator_alu_tb.sv
// Self-checking testbench for the operand stack calculator: stimulus, prediction and checks.
`timescale 1ns / 100ps

module stack_calculator_alu_tb;
  import sca_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS  = 150;

  // Opcodes the block treats as no-ops.
  localparam logic [OPC_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OPC_W-1:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MIN       = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX       = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MINUS_ONE = 32'hffff_ffff;

  typedef struct packed {
    status_e              status;
    logic [DEPTH_W-1:0]   depth;
    logic [DATA_W-1:0]    top;
  } calc_result_t;

  // Tracks the operand stack and holds the results still owed by the block.
  class calc_scoreboard;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       entries;
    calc_result_t      results_due [$];
    int unsigned       errors;
    int unsigned       items_taken;
    int unsigned       results_checked;
    int unsigned       deepest;
    int unsigned       status_seen [4];
    int unsigned       op_seen [8];

    task report(string msg);
      $display("MISMATCH at result %0d: %s", results_checked, msg);
      errors++;
    endtask

    // Applies one accepted item to the stack and queues the result it must produce.
    task take_item(logic [OPC_W-1:0] op, logic [DATA_W-1:0] val);
      calc_result_t      res;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] value;
      res.status = STAT_OK;
      if (op == OP_PUSH) begin
        if (entries >= STACK_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          operands[entries] = val;
          entries++;
        end
      end else if (op >= OP_ADD && op <= OP_SUB) begin
        if (entries < 2) begin
          res.status = STAT_FEW;
        end else begin
          lhs   = operands[entries-2];
          rhs   = operands[entries-1];
          value = '0;
          case (op)
            OP_ADD: value = lhs + rhs;
            OP_MUL: value = lhs * rhs;
            OP_DIV: begin
              if (rhs == '0) begin
                res.status = STAT_DIVZ;
              end else if (lhs == VAL_MIN && rhs == VAL_MINUS_ONE) begin
                // The one overflowing quotient wraps back to the most negative value.
                value = VAL_MIN;
              end else begin
                value = $signed(lhs) / $signed(rhs);
              end
            end
            default: value = lhs - rhs;
          endcase
          // Errors leave the stack as it was.
          if (res.status == STAT_OK) begin
            entries--;
            operands[entries-1] = value;
          end
        end
      end
      res.depth = entries[DEPTH_W-1:0];
      res.top   = (entries != 0) ? operands[entries-1] : '0;
      results_due.push_back(res);
      items_taken++;
      op_seen[op]++;
      status_seen[res.status]++;
      if (entries > deepest) deepest = entries;
    endtask

    // Compares one result transfer with the oldest outstanding prediction.
    task check_result(logic [STAT_W-1:0] status, logic [DEPTH_W-1:0] depth,
                      logic [DATA_W-1:0] top);
      calc_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result, status %0d depth %0d top %h", status, depth, top));
      end else begin
        want = results_due.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, predicted %s", status, want.status.name()));
        if (depth !== want.depth)
          report($sformatf("depth %0d, predicted %0d", depth, want.depth));
        if (top !== want.top)
          report($sformatf("top value %h, predicted %h", top, want.top));
      end
      results_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sca_in_if  in_ch ();
  sca_out_if out_ch ();

  calc_scoreboard sb = new();

  // Idle and stall rates in percent, set per phase by the main sequence.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Long receiver hold-offs asked for and started.
  int unsigned hold_requests;
  int unsigned hold_served;

  stack_calculator_alu #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offers one item, with random idle cycles ahead of it, and waits for its transfer.
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid      <= 1'b0;
      in_ch.opcode     <= OPC_W'($urandom);
      in_ch.push_value <= $urandom;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.push_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_item(op, val);
  endtask

  // Random items steered by the current stack depth so that most operations find operands.
  task automatic send_random(input int unsigned count);
    int unsigned       push_pct;
    int unsigned       pick;
    logic [OPC_W-1:0]  op;
    logic [DATA_W-1:0] val;
    for (int unsigned i = 0; i < count; i++) begin
      // Stretches that build the stack up alternate with stretches that work it down.
      push_pct = ((i / 40) % 2 == 0) ? 45 : 75;
      if (sb.entries < 2) push_pct = 80;
      else if (sb.entries >= STACK_DEPTH) push_pct = 20;
      pick = $urandom_range(99);
      if (pick < 3) op = OPC_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      else if (pick < 3 + push_pct) op = OP_PUSH;
      else op = OPC_W'($urandom_range(OP_SUB, OP_ADD));
      case ($urandom_range(7))
        0: val = '0;
        1: val = DATA_W'($urandom_range(8)) - 32'd4;
        2: begin
          case ($urandom_range(3))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2:       val = VAL_MINUS_ONE;
            default: val = 32'd1;
          endcase
        end
        default: val = $urandom;
      endcase
      send_item(op, val);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every result transfer is checked at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.depth, out_ch.top_value);
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TIMEOUT: no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sb.results_due.size());
    $display("Mismatches found");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_PUSH;
    in_ch.push_value = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_requests    = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: short stack, extreme operands, overflowing divide, zero divisor, no-ops.
    send_item(OP_ADD, VAL_MAX);
    send_item(OP_PUSH, VAL_MIN);
    send_item(OP_PUSH, VAL_MINUS_ONE);
    send_item(OP_DIV, '0);
    send_item(OP_PUSH, '0);
    send_item(OP_DIV, '0);
    for (int u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++) send_item(OPC_W'(u), VAL_MAX);
    send_item(OP_MUL, '0);
    send_item(OP_SUB, '0);
    send_item(OP_PUSH, VAL_MAX);
    send_item(OP_PUSH, 32'd1);
    send_item(OP_ADD, '0);
    // Fill the stack to capacity, then push once more.
    while (sb.entries < STACK_DEPTH) send_item(OP_PUSH, $urandom);
    send_item(OP_PUSH, VAL_MAX);

    // Random phases with different idle patterns on each side.
    send_random(PHASE_ITEMS);
    send_idle_pct = 49;
    send_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    send_random(PHASE_ITEMS);

    // Back-pressure: the receiver holds off while items keep coming.
    recv_stall_pct = 0;
    hold_requests++;
    send_random(20);

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    send_random(PHASE_ITEMS);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d results: %0d ok, %0d pushes onto a full stack,",
             sb.items_taken, sb.results_checked, sb.status_seen[STAT_OK],
             sb.status_seen[STAT_FULL]);
    $display("%0d short-stack operations, %0d zero divisors; %0d divides, deepest stack %0d.",
             sb.status_seen[STAT_FEW], sb.status_seen[STAT_DIVZ], sb.op_seen[OP_DIV],
             sb.deepest);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
